// ===== rtl/xa_dec_pkg.sv =====
// Shared types, constants and arithmetic for the XA ADPCM block decoder.
// Depends on nothing; imported by xa_adpcm_block_decoder.
package xa_dec_pkg;

   // Block layout: four header bytes, then fifteen bytes of two codes each.
   localparam int unsigned BLOCK_BYTES = 19;
   localparam int unsigned POS_W       = 5;
   localparam int unsigned IDX_W       = 5;
   localparam int unsigned SAMPLE_W    = 16;
   localparam int unsigned HIST_W      = 32;
   localparam int unsigned ACC_W       = 41;
   localparam int unsigned REQ_DATA_W  = 8;
   localparam int unsigned RSP_DATA_W  = 24;

   localparam logic [POS_W-1:0] POS_FILTER  = 5'd0;
   localparam logic [POS_W-1:0] POS_SEED_A  = 5'd1;
   localparam logic [POS_W-1:0] POS_SHIFT   = 5'd2;
   localparam logic [POS_W-1:0] POS_SEED_B  = 5'd3;
   localparam logic [POS_W-1:0] POS_LAST    = 5'(BLOCK_BYTES - 1);
   localparam logic [IDX_W-1:0] IDX_LAST    = 5'd31;
   localparam logic [3:0]       SHIFT_LIMIT = 4'd13;

   // Filter selector codes (low two bits of the selector nibble).
   typedef enum logic [1:0] {
      FILT_NONE = 2'd0,
      FILT_ONE  = 2'd1,
      FILT_TWO  = 2'd2,
      FILT_THREE = 2'd3
   } filt_type;

   // One decoded sample as it leaves the block.
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic [IDX_W-1:0]           index;
      logic                       last;
   } result_type;

   // Seed in Q.6: (low & 0xF0) + 256 * signed high byte, scaled by 64.
   function automatic logic signed [HIST_W-1:0] seed_q6(input logic [3:0] low_hi,
                                                        input logic [7:0] high);
      logic signed [21:0] s;
      s = $signed({high, low_hi, 10'b0});
      return HIST_W'(s);
   endfunction

   // One predictor step: Q.12 sum, rounded to Q.6 and saturated to 32 bits.
   function automatic logic signed [HIST_W-1:0] predict(input logic [3:0] nib,
                                                        input filt_type filt,
                                                        input logic [3:0] shift,
                                                        input logic signed [HIST_W-1:0] prev,
                                                        input logic signed [HIST_W-1:0] older);
      logic signed [ACC_W-1:0] pe;
      logic signed [ACC_W-1:0] oe;
      logic signed [ACC_W-1:0] acc;
      logic signed [ACC_W-1:0] term;
      logic signed [ACC_W-1:0] rnd;
      logic signed [34:0]      q;
      pe = ACC_W'(prev);
      oe = ACC_W'(older);
      unique case (filt)
         FILT_NONE:  acc = '0;
         FILT_ONE:   acc = pe * 41'sd60;
         FILT_TWO:   acc = pe * 41'sd115 - oe * 41'sd52;
         FILT_THREE: acc = pe * 41'sd98 - oe * 41'sd55;
         default:    acc = '0;
      endcase
      // Codes contribute nothing once the shift reaches thirteen.
      if (shift < SHIFT_LIMIT) begin
         term = ACC_W'($signed(nib)) <<< (5'd24 - {1'b0, shift});
      end else begin
         term = '0;
      end
      rnd = acc + term + 41'sd32;
      q   = 35'(rnd >>> 6);
      if (q > 35'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (q < -35'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return HIST_W'(q);
   endfunction

   // Q.6 history value to a sample: truncate toward zero, saturate to 16 bits.
   function automatic logic signed [SAMPLE_W-1:0] to_sample(input logic signed [HIST_W-1:0] q);
      logic signed [HIST_W-1:0] t;
      logic signed [25:0]       s;
      t = (q < 0) ? q + 32'sd63 : q;
      s = 26'(t >>> 6);
      if (s > 26'sd32767) begin
         return 16'sh7FFF;
      end else if (s < -26'sd32768) begin
         return 16'sh8000;
      end
      return SAMPLE_W'(s);
   endfunction

endpackage

// ===== rtl/xa_adpcm_block_decoder.sv =====
// XA ADPCM block decoder: 19-byte blocks in, 32 signed 16-bit samples out.
// Path: each accepted byte is registered in the input register, and its samples in the
// result buffer that drives rsp_. Header bytes are taken one per cycle while rsp_tready
// is high; a code byte waits until the single result port has room for its two samples.
// Reset: synchronous, active high; clears the byte position, selectors, history,
// sample index, the input valid flag and the result buffer count; payloads are not reset.
// Depends on xa_dec_pkg.
module xa_adpcm_block_decoder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [xa_dec_pkg::REQ_DATA_W-1:0]   req_tdata,  // [7:0] data_byte
   input  logic                                req_tuser,  // [0] block_start
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [xa_dec_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // [15:0] sample, [20:16] sample_index
   output logic                                rsp_tlast   // last_in_block
);
   import xa_dec_pkg::*;

   // Input register.
   logic                  in_v_ff, in_v_in;
   logic [7:0]            in_byte_ff;
   logic                  in_start_ff;

   // Decoder state.
   logic [POS_W-1:0]         pos_ff, pos_in;
   filt_type                 filt_ff, filt_in;
   logic [3:0]               shift_ff, shift_in;
   logic [3:0]               hdr_ff, hdr_in;
   logic signed [HIST_W-1:0] prev_ff, prev_in;
   logic signed [HIST_W-1:0] older_ff, older_in;
   logic [IDX_W-1:0]         oidx_ff, oidx_in;

   // Result buffer: two entries, s0 is at the head.
   logic [1:0]  cnt_ff, cnt_in;
   result_type  s0_ff, s0_in;
   result_type  s1_ff, s1_in;

   logic [POS_W-1:0]         pos;
   logic [1:0]               nres;
   logic signed [HIST_W-1:0] q0, q1;
   result_type               r0, r1;
   logic                     pop, advance, room;

   // Handshakes.
   assign pop        = (cnt_ff != 2'd0) && rsp_tready;
   assign room       = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && pop);
   assign advance    = in_v_ff && ((nres == 2'd0) || room);
   assign req_tready = !in_v_ff || advance;
   assign in_v_in    = (req_tvalid && req_tready) || (in_v_ff && !advance);

   // Decode one byte against the current state.
   always_comb begin
      pos = (in_start_ff || (pos_ff >= POS_W'(BLOCK_BYTES))) ? POS_FILTER : pos_ff;
      filt_in  = filt_ff;
      shift_in = shift_ff;
      hdr_in   = hdr_ff;
      prev_in  = prev_ff;
      older_in = older_ff;
      oidx_in  = oidx_ff;
      pos_in   = pos_ff;
      nres     = 2'd0;
      q0       = '0;
      q1       = '0;
      unique case (pos)
         POS_FILTER: begin
            hdr_in  = in_byte_ff[7:4];
            filt_in = filt_type'(in_byte_ff[1:0]);
            oidx_in = '0;
         end
         POS_SEED_A: begin
            q0      = seed_q6(hdr_ff, in_byte_ff);
            prev_in = q0;
            nres    = 2'd1;
         end
         POS_SHIFT: begin
            hdr_in   = in_byte_ff[7:4];
            shift_in = in_byte_ff[3:0];
         end
         POS_SEED_B: begin
            q0       = seed_q6(hdr_ff, in_byte_ff);
            older_in = prev_ff;
            prev_in  = q0;
            nres     = 2'd1;
         end
         default: begin
            // High nibble first, then the low nibble on the updated history.
            q0       = predict(in_byte_ff[7:4], filt_ff, shift_ff, prev_ff, older_ff);
            q1       = predict(in_byte_ff[3:0], filt_ff, shift_ff, q0, prev_ff);
            older_in = q0;
            prev_in  = q1;
            nres     = 2'd2;
         end
      endcase
      if (pos != POS_FILTER) begin
         oidx_in = oidx_ff + IDX_W'(nres);
      end
      if (advance) begin
         pos_in = (pos == POS_LAST) ? POS_FILTER : pos + 5'd1;
      end else begin
         filt_in  = filt_ff;
         shift_in = shift_ff;
         hdr_in   = hdr_ff;
         prev_in  = prev_ff;
         older_in = older_ff;
         oidx_in  = oidx_ff;
      end
      r0.sample = to_sample(q0);
      r0.index  = oidx_ff;
      r0.last   = (oidx_ff == IDX_LAST);
      r1.sample = to_sample(q1);
      r1.index  = oidx_ff + 5'd1;
      r1.last   = ((oidx_ff + 5'd1) == IDX_LAST);
   end

   // Result buffer next state.
   always_comb begin
      s0_in  = s0_ff;
      s1_in  = s1_ff;
      cnt_in = cnt_ff;
      if (advance && (nres != 2'd0)) begin
         s0_in  = r0;
         s1_in  = r1;
         cnt_in = nres;
      end else if (pop) begin
         if (cnt_ff == 2'd2) begin
            s0_in = s1_ff;
         end
         cnt_in = cnt_ff - 2'd1;
      end
   end

   // Control and history registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff  <= 1'b0;
         pos_ff   <= '0;
         filt_ff  <= FILT_NONE;
         shift_ff <= '0;
         hdr_ff   <= '0;
         prev_ff  <= '0;
         older_ff <= '0;
         oidx_ff  <= '0;
         cnt_ff   <= '0;
      end else begin
         in_v_ff  <= in_v_in;
         pos_ff   <= pos_in;
         filt_ff  <= filt_in;
         shift_ff <= shift_in;
         hdr_ff   <= hdr_in;
         prev_ff  <= prev_in;
         older_ff <= older_in;
         oidx_ff  <= oidx_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff  <= req_tdata;
         in_start_ff <= req_tuser;
      end
      s0_ff <= s0_in;
      s1_ff <= s1_in;
   end

   // Result port.
   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = {3'b0, s0_ff.index, s0_ff.sample};
   assign rsp_tlast  = s0_ff.last;

   // The result buffer never holds more than two beats.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("result buffer count out of range");

   // The byte position stays inside the block.
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff < POS_W'(BLOCK_BYTES)) else $error("byte position out of range");

   // New results are only loaded once the buffer is draining empty.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (advance && (nres != 2'd0)) |-> room) else $error("result buffer overrun");

   // The last flag follows the sample index.
   a_last_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[20:16] == IDX_LAST)))
      else $error("last flag does not match sample index");

   // A filter header byte restarts the sample count.
   a_idx_restart: assert property (@(posedge clock) disable iff (reset)
      (advance && (pos == POS_FILTER)) |=> (oidx_ff == '0))
      else $error("sample index not restarted at block start");

endmodule
